>>> sv/closed_cubic_bspline_eval_unit_defines.svh
// Assertion macros shared by the spline evaluator modules.
// Expects clk and rst_n in the scope of every use.
`ifndef CLOSED_CUBIC_BSPLINE_EVAL_UNIT_DEFINES_SVH
`define CLOSED_CUBIC_BSPLINE_EVAL_UNIT_DEFINES_SVH

// Property checked at every edge outside reset.
`define CCBSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CCBSE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> sv/ccbse_pkg.sv
// Types and constants of the closed cubic B-spline evaluator.
// Used by ccbse_lane, ccbse_dpath, ccbse_ctrl and the top level; no dependencies.
package ccbse_pkg;

  localparam int REQ_W   = 2;
  localparam int PT_W    = 10;
  localparam int SEG_W   = 6;
  localparam int J_W     = 7;
  localparam int OUT_W   = 18;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // t in Q1.16, with 1.0 held as 65536
  localparam int T_FRAC = 16;
  localparam int T_W    = 17;
  localparam int T_ONE  = 65536;

  localparam int MIN_POINTS = 3;

  // Horner datapath
  localparam int C_W     = 14;  // signed polynomial coefficients
  localparam int C0_W    = 13;  // unsigned constant coefficient
  localparam int ACC_W   = 64;
  localparam int MA_W    = 33;
  localparam int MB_W    = 21;
  localparam int MP_W    = MA_W + MB_W + 1;
  localparam int SPLIT_W = 24;  // low part of the second Horner value
  localparam int HI_W    = 25;  // high part, signed

  // Rounding: floor((acc + 3*2^40) / 2^41) then divide by three
  localparam int RND_SH   = 40;
  localparam int A_LSB    = 41;
  localparam int A_W      = 20;
  localparam int RECIP_SH = 22;
  localparam logic [MB_W-1:0] RECIP3 = MB_W'(((1 << RECIP_SH) + 2) / 3);
  localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(3) << RND_SH;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_EVAL   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_H1,
    OP_H2,
    OP_HI,
    OP_LO,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic load;
    logic rd_en;
    logic shift;
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic eval_err;
  } status_t;

endpackage

>>> sv/closed_cubic_bspline_eval_unit.sv
// Closed uniform cubic B-spline evaluator, top level.
// Input channel in_*: in_tuser carries the request kind (clear, append, evaluate);
// in_tdata carries the point coordinates, the segment and the sample number.
// Clear and append are acted on at accept and produce no item on out_*.
// An append to a full store is dropped; request kind 3 is accepted and ignored.
// Evaluate produces one item: x and y in Q10.8 on out_tdata, error flag on out_tuser.
// Input ready returns with the result, so the block takes no new item while an
// evaluate runs: four reads of the single-read-port point store, one capture,
// then four Horner steps and a divide-by-three step on one multiplier
// per coordinate.
// A refused evaluate (fewer than three points or segment not held) skips to the final step.
// One result register parts the channels: the block takes new items while a result
// waits, and stalls only in its final step when a second result is ready.
// Reset empties the store (count to zero) and drops any pending result; point
// entries themselves are not cleared and need no clearing pass.
// Dependencies: ccbse_pkg, ccbse_ctrl, ccbse_dpath, ccbse_lane.
module closed_cubic_bspline_eval_unit #(
  parameter int MAX_POINTS          = 64,
  parameter int SAMPLES_PER_SEGMENT = 100
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [32:26] sample_index, [25:20] segment_index, [19:10] y_in, [9:0] x_in
  input  logic [ccbse_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] req_type
  input  logic [ccbse_pkg::REQ_W-1:0]          in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [35:18] y_out, [17:0] x_out
  output logic [ccbse_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] eval_error
  output logic                                 out_tuser
);

  localparam int PT_W  = ccbse_pkg::PT_W;
  localparam int SEG_W = ccbse_pkg::SEG_W;
  localparam int J_W   = ccbse_pkg::J_W;
  localparam int OUT_W = ccbse_pkg::OUT_W;
  localparam int SEG_L = 2 * PT_W;
  localparam int J_L   = SEG_L + SEG_W;

  ccbse_pkg::cmd_t    cmd;
  ccbse_pkg::status_t status;
  logic [OUT_W-1:0]   x_out, y_out;
  logic               eval_error;

  ccbse_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_req_type (in_tuser),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .status      (status)
  );

  ccbse_dpath #(
    .MAX_POINTS          (MAX_POINTS),
    .SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .x_in          (in_tdata[PT_W-1:0]),
    .y_in          (in_tdata[2*PT_W-1:PT_W]),
    .segment_index (in_tdata[SEG_L+SEG_W-1:SEG_L]),
    .sample_index  (in_tdata[J_L+J_W-1:J_L]),
    .x_out         (x_out),
    .y_out         (y_out),
    .eval_error    (eval_error)
  );

  assign out_tdata = {{(ccbse_pkg::OUT_TDATA_W - 2 * OUT_W){1'b0}}, y_out, x_out};
  assign out_tuser = eval_error;

endmodule

>>> sv/ccbse_lane.sv
// One coordinate lane: four point registers, coefficients and a Horner
// evaluator on a single 33x21 multiplier. Depends on ccbse_pkg.
module ccbse_lane (
  input  logic                          clk,
  input  ccbse_pkg::op_t                op,
  input  logic                          shift,
  input  logic [ccbse_pkg::PT_W-1:0]    pt_in,
  input  logic [ccbse_pkg::T_W-1:0]     t_in,
  output logic [ccbse_pkg::OUT_W-1:0]   quot
);

  localparam int PT_W    = ccbse_pkg::PT_W;
  localparam int C_W     = ccbse_pkg::C_W;
  localparam int C0_W    = ccbse_pkg::C0_W;
  localparam int ACC_W   = ccbse_pkg::ACC_W;
  localparam int MA_W    = ccbse_pkg::MA_W;
  localparam int MB_W    = ccbse_pkg::MB_W;
  localparam int MP_W    = ccbse_pkg::MP_W;
  localparam int T_FRAC  = ccbse_pkg::T_FRAC;
  localparam int SPLIT_W = ccbse_pkg::SPLIT_W;
  localparam int HI_W    = ccbse_pkg::HI_W;
  localparam int A_LSB   = ccbse_pkg::A_LSB;
  localparam int A_W     = ccbse_pkg::A_W;
  localparam int OUT_W   = ccbse_pkg::OUT_W;
  localparam int RSH     = ccbse_pkg::RECIP_SH;

  logic        [PT_W-1:0]  p_r [4];
  logic signed [C_W-1:0]   pe0, pe1, pe2, pe3;
  logic signed [C_W-1:0]   d20, e2, d12, c1, c2, c3;
  logic        [C0_W-1:0]  c0;
  logic signed [MA_W-1:0]  mul_a;
  logic        [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  prod;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  always_ff @(posedge clk) begin
    if (shift) begin
      p_r[3] <= pt_in;
      p_r[2] <= p_r[3];
      p_r[1] <= p_r[2];
      p_r[0] <= p_r[1];
    end
    acc_r <= acc_nxt;
  end

  // Curve as c0*2^48 + c1*t*2^32 + c2*t^2*2^16 + c3*t^3
  always_comb begin
    pe0 = $signed(C_W'(p_r[0]));
    pe1 = $signed(C_W'(p_r[1]));
    pe2 = $signed(C_W'(p_r[2]));
    pe3 = $signed(C_W'(p_r[3]));
    d20 = pe2 - pe0;
    e2  = pe0 - (pe1 <<< 1) + pe2;
    d12 = pe1 - pe2;
    c1  = (d20 <<< 1) + d20;
    c2  = (e2 <<< 1) + e2;
    c3  = (d12 <<< 1) + d12 - pe0 + pe3;
    c0  = C0_W'(p_r[0]) + (C0_W'(p_r[1]) << 2) + C0_W'(p_r[2]);
  end

  assign prod = mul_a * $signed({1'b0, mul_b});
  assign quot = prod[RSH+OUT_W-1:RSH];

  always_comb begin
    mul_a   = '0;
    mul_b   = MB_W'(t_in);
    acc_nxt = acc_r;
    unique case (op)
      ccbse_pkg::OP_H1: begin
        mul_a   = MA_W'(c3);
        acc_nxt = ACC_W'(prod) + (ACC_W'(c2) <<< T_FRAC);
      end
      ccbse_pkg::OP_H2: begin
        mul_a   = $signed(acc_r[MA_W-1:0]);
        acc_nxt = ACC_W'(prod) + (ACC_W'(c1) <<< (2 * T_FRAC));
      end
      ccbse_pkg::OP_HI: begin
        // high part times t, keep the low part in place below it
        mul_a   = MA_W'($signed(acc_r[SPLIT_W+HI_W-1:SPLIT_W]));
        acc_nxt = (ACC_W'(prod) <<< SPLIT_W) + ACC_W'(acc_r[SPLIT_W-1:0]);
      end
      ccbse_pkg::OP_LO: begin
        mul_a   = MA_W'(acc_r[SPLIT_W-1:0]);
        acc_nxt = {acc_r[ACC_W-1:SPLIT_W], {SPLIT_W{1'b0}}} + ACC_W'(prod)
                  + (ACC_W'(c0) << (3 * T_FRAC)) + ccbse_pkg::RND_BIAS;
      end
      ccbse_pkg::OP_DIV: begin
        mul_a = MA_W'(acc_r[A_LSB+A_W-1:A_LSB]);
        mul_b = ccbse_pkg::RECIP3;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

endmodule

>>> sv/ccbse_dpath.sv
// Datapath: control point stores, point count, t table, two coordinate
// lanes and the result register. Depends on ccbse_pkg, ccbse_lane and the defines header.
`include "closed_cubic_bspline_eval_unit_defines.svh"

module ccbse_dpath #(
  parameter int MAX_POINTS          = 64,
  parameter int SAMPLES_PER_SEGMENT = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ccbse_pkg::cmd_t               cmd,
  output ccbse_pkg::status_t            status,
  input  logic [ccbse_pkg::PT_W-1:0]    x_in,
  input  logic [ccbse_pkg::PT_W-1:0]    y_in,
  input  logic [ccbse_pkg::SEG_W-1:0]   segment_index,
  input  logic [ccbse_pkg::J_W-1:0]     sample_index,
  output logic [ccbse_pkg::OUT_W-1:0]   x_out,
  output logic [ccbse_pkg::OUT_W-1:0]   y_out,
  output logic                          eval_error
);

  localparam int PT_W  = ccbse_pkg::PT_W;
  localparam int T_W   = ccbse_pkg::T_W;
  localparam int OUT_W = ccbse_pkg::OUT_W;
  localparam int SEG_W = ccbse_pkg::SEG_W;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int SW    = (CW > SEG_W) ? CW : SEG_W;
  localparam int NJ    = 1 << ccbse_pkg::J_W;
  localparam int LAST  = SAMPLES_PER_SEGMENT - 1;

  logic [PT_W-1:0]  mem_x [MAX_POINTS];
  logic [PT_W-1:0]  mem_y [MAX_POINTS];
  logic [PT_W-1:0]  rd_x_r, rd_y_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    idx_r;
  logic [T_W-1:0]   t_r;
  logic             err_r;
  logic [OUT_W-1:0] x_out_r, y_out_r;
  logic             eval_error_r;
  logic [T_W-1:0]   t_lut [NJ];
  logic [SW-1:0]    seg_w, cnt_w;
  logic             full, load_err, idx_wrap;
  logic [OUT_W-1:0] quot_x, quot_y;

  // t = round(j * 65536 / (S-1)), j saturated at the last sample
  for (genvar j = 0; j < NJ; j++) begin : g_tq
    localparam int JS = (j > LAST) ? LAST : j;
    localparam int TQ = (JS * ccbse_pkg::T_ONE + LAST / 2) / LAST;
    assign t_lut[j] = T_W'(TQ);
  end

  assign full     = (count_r == CW'(MAX_POINTS));
  assign seg_w    = SW'(segment_index);
  assign cnt_w    = SW'(count_r);
  assign load_err = (count_r < CW'(ccbse_pkg::MIN_POINTS)) || (seg_w >= cnt_w);
  assign idx_wrap = ((CW'(idx_r) + CW'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append && !full) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem_x[AW'(count_r)] <= x_in;
      mem_y[AW'(count_r)] <= y_in;
    end
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[idx_r];
      rd_y_r <= mem_y[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= AW'(seg_w);
      t_r   <= t_lut[sample_index];
      err_r <= load_err;
    end else if (cmd.rd_en) begin
      // advance modulo the point count
      idx_r <= idx_wrap ? '0 : idx_r + AW'(1);
    end
    if (cmd.out_load) begin
      x_out_r      <= err_r ? '0 : quot_x;
      y_out_r      <= err_r ? '0 : quot_y;
      eval_error_r <= err_r;
    end
  end

  ccbse_lane u_lane_x (
    .clk   (clk),
    .op    (cmd.op),
    .shift (cmd.shift),
    .pt_in (rd_x_r),
    .t_in  (t_r),
    .quot  (quot_x)
  );

  ccbse_lane u_lane_y (
    .clk   (clk),
    .op    (cmd.op),
    .shift (cmd.shift),
    .pt_in (rd_y_r),
    .t_in  (t_r),
    .quot  (quot_y)
  );

  assign status.eval_err = err_r;
  assign x_out      = x_out_r;
  assign y_out      = y_out_r;
  assign eval_error = eval_error_r;

  `CCBSE_ASSERT_NEXT(a_full_drop, cmd.append && full && !cmd.clear, $stable(count_r), "append to full store changed count")
  `CCBSE_ASSERT_NEXT(a_clear, cmd.clear, count_r == '0, "clear did not empty the store")
  `CCBSE_ASSERT(a_rd_range, cmd.rd_en |-> (CW'(idx_r) < count_r), "store read beyond point count")

endmodule

>>> sv/ccbse_ctrl.sv
// Controller: sequences store reads and Horner steps per evaluate item and
// owns the input ready and the result valid. Depends on ccbse_pkg and the defines header.
`include "closed_cubic_bspline_eval_unit_defines.svh"

module ccbse_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic [ccbse_pkg::REQ_W-1:0]    in_req_type,
  output logic                           in_tready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output ccbse_pkg::cmd_t                cmd,
  input  ccbse_pkg::status_t             status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CAP,
    S_H1,
    S_H2,
    S_HI,
    S_LO,
    S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.op    = ccbse_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            ccbse_pkg::REQ_CLEAR:  cmd.clear  = 1'b1;
            ccbse_pkg::REQ_APPEND: cmd.append = 1'b1;
            ccbse_pkg::REQ_EVAL: begin
              cmd.load  = 1'b1;
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // capture the word read in the previous cycle
        cmd.shift = (k_r != 2'd0);
        if (status.eval_err) begin
          k_nxt     = 2'd0;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          k_nxt     = k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_nxt = S_CAP;
          end
        end
      end
      S_CAP: begin
        cmd.shift = 1'b1;
        state_nxt = S_H1;
      end
      S_H1: begin
        cmd.op    = ccbse_pkg::OP_H1;
        state_nxt = S_H2;
      end
      S_H2: begin
        cmd.op    = ccbse_pkg::OP_H2;
        state_nxt = S_HI;
      end
      S_HI: begin
        cmd.op    = ccbse_pkg::OP_HI;
        state_nxt = S_LO;
      end
      S_LO: begin
        cmd.op    = ccbse_pkg::OP_LO;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        cmd.op = ccbse_pkg::OP_DIV;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CCBSE_ASSERT_NEXT(a_eval_busy, accept && (in_req_type == ccbse_pkg::REQ_EVAL), !in_tready, "evaluate item did not block input")
  `CCBSE_ASSERT(a_valid_src, $rose(out_valid_r) |-> $past(state_r == S_FIN), "result valid rose outside final step")
  `CCBSE_ASSERT(a_no_overwrite, (out_valid_r && !out_tready) |-> !cmd.out_load, "pending result overwritten")

endmodule
